/* rtl/tournament_branch_direction_predictor_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the tournament branch direction predictor
// Implication and next-cycle forms, clocked and disabled under reset.
// ---------------------------------------------------------------------------
`ifndef TOURNAMENT_BRANCH_DIRECTION_PREDICTOR_TOP_ASSERT_SVH
`define TOURNAMENT_BRANCH_DIRECTION_PREDICTOR_TOP_ASSERT_SVH

// same-cycle implication
`define TBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tbp assertion failed");

// next-cycle implication
`define TBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tbp assertion failed");

`endif

/* rtl/tbp_pkg.sv */
// ---------------------------------------------------------------------------
// tbp_pkg
// Shared types, constants and counter helpers of the branch predictor.
// ---------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

	localparam int ADDR_W     = 48;
	localparam int HIST_W     = 12;
	localparam int PIDX_W     = 12;
	localparam int MAX_IDX_W  = 16;
	localparam int FOLD_SHIFT = 16;

	typedef logic [1:0] ctr_t;

	localparam ctr_t WEAK_LIMIT    = 2'd2;
	localparam ctr_t CTR_MAX       = 2'd3;
	localparam ctr_t CTR_EVEN_INIT = 2'd1;
	localparam ctr_t CTR_ODD_INIT  = 2'd2;

	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	typedef struct packed {
		logic                 active;
		logic [MAX_IDX_W-1:0] idx;
	} clr_t;

	// saturating step toward taken or not taken
	function automatic ctr_t ctr_bump(input ctr_t c, input logic up);
		ctr_t r;
		if (up) begin
			r = (c < CTR_MAX) ? ctr_t'(c + 2'd1) : CTR_MAX;
		end else begin
			r = (c != 2'd0) ? ctr_t'(c - 2'd1) : 2'd0;
		end
		return r;
	endfunction

	// power-up value: weak not taken at even index, weak taken at odd
	function automatic ctr_t ctr_init(input logic odd);
		return odd ? CTR_ODD_INIT : CTR_EVEN_INIT;
	endfunction

endpackage

`default_nettype wire

/* rtl/tbp_ctr_table.sv */
// ---------------------------------------------------------------------------
// tbp_ctr_table
// Counter memory with one read and one write port, registered read data
// and a bypass that returns a write made at the same edge as the read.
// ---------------------------------------------------------------------------
`default_nettype none

module tbp_ctr_table #(
	parameter int IDX_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [IDX_BITS-1:0] rd_addr,
	input  logic                wr_en,
	input  logic [IDX_BITS-1:0] wr_addr,
	input  tbp_pkg::ctr_t       wr_data,
	output tbp_pkg::ctr_t       rd_data
);
	import tbp_pkg::*;

	localparam int DEPTH = 1 << IDX_BITS;

	ctr_t mem [DEPTH];
	ctr_t rd_raw_q;
	ctr_t byp_data_q;
	logic byp_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q   <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// flag a read that collides with a write at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_raw_q;

endmodule

`default_nettype wire

/* rtl/tbp_clear_seq.sv */
// ---------------------------------------------------------------------------
// tbp_clear_seq
// Post-reset sweep that walks every counter index once so the tables
// can be loaded with their power-up values.
// ---------------------------------------------------------------------------
`default_nettype none

module tbp_clear_seq #(
	parameter int SWEEP_BITS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	output tbp_pkg::clr_t clr
);
	import tbp_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} clr_state_t;

	clr_state_t             state_q;
	logic [SWEEP_BITS-1:0]  cnt_q;

	// advance the sweep, stop after the last index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + SWEEP_BITS'(1);
					if (cnt_q == {SWEEP_BITS{1'b1}}) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign clr.active = (state_q == ST_CLEAR);
	assign clr.idx    = MAX_IDX_W'(cnt_q);

endmodule

`default_nettype wire

/* rtl/tournament_branch_direction_predictor_top.sv */
// An accepted transfer passes through the stage 1 registers (table reads and
// valid_s1) and then the result registers. Throughput: one item per cycle while busy is low.
// Results cannot be stalled; done is a one-cycle strobe.
// Reset: history clears and history_xor returns to 1, then a clearing pass
// over every counter index loads the counter tables while busy stays high;
// configuration writes are taken throughout.
// ---------------------------------------------------------------------------
// tournament_branch_direction_predictor_top
// Bimodal, two-level and chooser counter tables with global history.
// ---------------------------------------------------------------------------
`default_nettype none

module tournament_branch_direction_predictor_top #(
	parameter int BIMODAL_ENTRIES = 4096,
	parameter int CHOOSER_ENTRIES = 4096,
	parameter int PATTERN_ENTRIES = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_wr_data,
	input  logic                         start,
	output logic                         busy,
	input  logic                         op,
	input  logic [tbp_pkg::ADDR_W-1:0]   branch_addr,
	input  logic [tbp_pkg::ADDR_W-1:0]   target_addr,
	input  logic [tbp_pkg::PIDX_W-1:0]   saved_pattern_index,
	input  logic                         saved_bimodal_vote,
	input  logic                         saved_twolevel_vote,
	output logic                         done,
	output logic                         pred_taken,
	output logic [tbp_pkg::ADDR_W-1:0]   next_addr,
	output logic [tbp_pkg::PIDX_W-1:0]   pattern_index,
	output logic                         bimodal_vote,
	output logic                         twolevel_vote,
	output logic                         chooser_vote
);
	import tbp_pkg::*;

	// usable index width: log2 of the largest power of two not above the entry count
	localparam int BI_W = $clog2(BIMODAL_ENTRIES + 1) - 1;
	localparam int CI_W = $clog2(CHOOSER_ENTRIES + 1) - 1;
	localparam int PI_W = $clog2(PATTERN_ENTRIES + 1) - 1;
	localparam int BC_W = (BI_W > CI_W) ? BI_W : CI_W;
	localparam int SWEEP_W = (BC_W > PI_W) ? BC_W : PI_W;

	clr_t                  clr;
	logic                  accept;
	logic                  history_xor_q;
	logic [HIST_W-1:0]     history_q;

	logic [ADDR_W-1:0]     fold_s0;
	logic [BI_W-1:0]       bi_s0;
	logic [CI_W-1:0]       ci_s0;
	logic [ADDR_W-1:0]     pi_xor_s0;
	logic [ADDR_W+HIST_W-1:0] pi_cat_s0;
	logic [PI_W-1:0]       pi_pred_s0;
	logic [MAX_IDX_W-1:0]  spi_ext_s0;
	logic [PI_W-1:0]       pi_s0;
	logic [MAX_IDX_W-1:0]  pi_ext_s0;
	logic [PIDX_W-1:0]     pidx_out_s0;
	logic                  taken_s0;

	logic                  valid_s1;
	logic                  op_s1;
	logic                  taken_s1;
	logic [BI_W-1:0]       bi_s1;
	logic [CI_W-1:0]       ci_s1;
	logic [PI_W-1:0]       pi_s1;
	logic [PIDX_W-1:0]     pidx_out_s1;
	logic                  sb_s1;
	logic                  st_s1;
	logic [ADDR_W-1:0]     baddr_s1;
	logic [ADDR_W-1:0]     taddr_s1;

	ctr_t                  bctr_s1;
	ctr_t                  cctr_s1;
	ctr_t                  pctr_s1;
	logic                  bv_s1;
	logic                  tv_s1;
	logic                  cv_s1;
	logic                  pred_s1;
	logic                  upd_s1;
	logic                  chooser_upd_s1;

	logic                  b_wr_en;
	logic [BI_W-1:0]       b_wr_addr;
	ctr_t                  b_wr_data;
	logic                  c_wr_en;
	logic [CI_W-1:0]       c_wr_addr;
	ctr_t                  c_wr_data;
	logic                  p_wr_en;
	logic [PI_W-1:0]       p_wr_addr;
	ctr_t                  p_wr_data;

	logic                  done_q;
	logic                  pred_taken_q;
	logic [ADDR_W-1:0]     next_addr_q;
	logic [PIDX_W-1:0]     pattern_index_q;
	logic                  bimodal_vote_q;
	logic                  twolevel_vote_q;
	logic                  chooser_vote_q;

	tbp_clear_seq #(
		.SWEEP_BITS(SWEEP_W)
	) u_clear_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr)
	);

	assign busy   = clr.active;
	assign accept = start && !busy;

	// hold the index mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_xor_q <= 1'b1;
		end else if (cfg_wr_en) begin
			history_xor_q <= cfg_wr_data;
		end
	end

	// form table indices from the incoming item
	always_comb begin
		fold_s0     = (branch_addr >> FOLD_SHIFT) ^ branch_addr;
		bi_s0       = fold_s0[BI_W-1:0];
		ci_s0       = fold_s0[CI_W-1:0];
		pi_xor_s0   = ADDR_W'(history_q) ^ branch_addr;
		pi_cat_s0   = {branch_addr, history_q};
		pi_pred_s0  = history_xor_q ? pi_xor_s0[PI_W-1:0] : pi_cat_s0[PI_W-1:0];
		spi_ext_s0  = MAX_IDX_W'(saved_pattern_index);
		pi_s0       = (op == OP_UPDATE) ? spi_ext_s0[PI_W-1:0] : pi_pred_s0;
		pi_ext_s0   = MAX_IDX_W'(pi_pred_s0);
		pidx_out_s0 = (op == OP_UPDATE) ? saved_pattern_index : pi_ext_s0[PIDX_W-1:0];
		taken_s0    = (target_addr != branch_addr);
	end

	// shift the resolved outcome into history as the update is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q <= '0;
		end else if (accept && (op == OP_UPDATE)) begin
			history_q <= {history_q[HIST_W-2:0], taken_s0};
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op;
			taken_s1    <= taken_s0;
			bi_s1       <= bi_s0;
			ci_s1       <= ci_s0;
			pi_s1       <= pi_s0;
			pidx_out_s1 <= pidx_out_s0;
			sb_s1       <= saved_bimodal_vote;
			st_s1       <= saved_twolevel_vote;
			baddr_s1    <= branch_addr;
			taddr_s1    <= target_addr;
		end
	end

	// votes and training decisions on the read counters
	always_comb begin
		bv_s1          = (bctr_s1 >= WEAK_LIMIT);
		tv_s1          = (pctr_s1 >= WEAK_LIMIT);
		cv_s1          = (cctr_s1 >= WEAK_LIMIT);
		pred_s1        = cv_s1 ? tv_s1 : bv_s1;
		upd_s1         = valid_s1 && (op_s1 == OP_UPDATE);
		chooser_upd_s1 = upd_s1 && (sb_s1 != st_s1);
	end

	// write ports: power-up values during the sweep, training afterwards
	always_comb begin
		if (clr.active) begin
			b_wr_en   = 1'b1;
			b_wr_addr = clr.idx[BI_W-1:0];
			b_wr_data = ctr_init(clr.idx[0]);
			c_wr_en   = 1'b1;
			c_wr_addr = clr.idx[CI_W-1:0];
			c_wr_data = ctr_init(clr.idx[0]);
			p_wr_en   = 1'b1;
			p_wr_addr = clr.idx[PI_W-1:0];
			p_wr_data = ctr_init(clr.idx[0]);
		end else begin
			b_wr_en   = upd_s1;
			b_wr_addr = bi_s1;
			b_wr_data = ctr_bump(bctr_s1, taken_s1);
			c_wr_en   = chooser_upd_s1;
			c_wr_addr = ci_s1;
			c_wr_data = ctr_bump(cctr_s1, st_s1 == taken_s1);
			p_wr_en   = upd_s1;
			p_wr_addr = pi_s1;
			p_wr_data = ctr_bump(pctr_s1, taken_s1);
		end
	end

	tbp_ctr_table #(
		.IDX_BITS(BI_W)
	) u_bimodal (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (bi_s0),
		.wr_en   (b_wr_en),
		.wr_addr (b_wr_addr),
		.wr_data (b_wr_data),
		.rd_data (bctr_s1)
	);

	tbp_ctr_table #(
		.IDX_BITS(CI_W)
	) u_chooser (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (ci_s0),
		.wr_en   (c_wr_en),
		.wr_addr (c_wr_addr),
		.wr_data (c_wr_data),
		.rd_data (cctr_s1)
	);

	tbp_ctr_table #(
		.IDX_BITS(PI_W)
	) u_pattern (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (pi_s0),
		.wr_en   (p_wr_en),
		.wr_addr (p_wr_addr),
		.wr_data (p_wr_data),
		.rd_data (pctr_s1)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	// result payload; update items return zero prediction and echo saved votes
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pattern_index_q <= pidx_out_s1;
			chooser_vote_q  <= cv_s1;
			if (op_s1 == OP_UPDATE) begin
				pred_taken_q    <= 1'b0;
				next_addr_q     <= '0;
				bimodal_vote_q  <= sb_s1;
				twolevel_vote_q <= st_s1;
			end else begin
				pred_taken_q    <= pred_s1;
				next_addr_q     <= pred_s1 ? taddr_s1 : baddr_s1;
				bimodal_vote_q  <= bv_s1;
				twolevel_vote_q <= tv_s1;
			end
		end
	end

	assign done          = done_q;
	assign pred_taken    = pred_taken_q;
	assign next_addr     = next_addr_q;
	assign pattern_index = pattern_index_q;
	assign bimodal_vote  = bimodal_vote_q;
	assign twolevel_vote = twolevel_vote_q;
	assign chooser_vote  = chooser_vote_q;

endmodule

`default_nettype wire

/* rtl/tbp_checker.sv */
// ---------------------------------------------------------------------------
// tbp_checker
// Port-level checks on the predictor: result timing and result contents.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tournament_branch_direction_predictor_top_assert.svh"

module tbp_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic                         op,
	input  logic [tbp_pkg::ADDR_W-1:0]   branch_addr,
	input  logic [tbp_pkg::ADDR_W-1:0]   target_addr,
	input  logic [tbp_pkg::PIDX_W-1:0]   saved_pattern_index,
	input  logic                         saved_bimodal_vote,
	input  logic                         saved_twolevel_vote,
	input  logic                         done,
	input  logic                         pred_taken,
	input  logic [tbp_pkg::ADDR_W-1:0]   next_addr,
	input  logic [tbp_pkg::PIDX_W-1:0]   pattern_index,
	input  logic                         bimodal_vote,
	input  logic                         twolevel_vote,
	input  logic                         chooser_vote
);
	import tbp_pkg::*;

	logic accept;
	logic vote_ok;

	assign accept  = start && !busy;
	assign vote_ok = (pred_taken == (chooser_vote ? twolevel_vote : bimodal_vote));

	// every accepted transfer gives a result, and every result comes from an accepted transfer
	`TBP_ASSERT_NXT(a_accept_gives_done, clk, arst_n, $past(accept), done)
	`TBP_ASSERT_IMP(a_done_had_accept, clk, arst_n, done, $past(accept, 2))

	// predict result: chosen vote and the address it implies
	`TBP_ASSERT_IMP(a_predict_result, clk, arst_n,
		done && ($past(op, 2) == OP_PREDICT),
		vote_ok && (next_addr == (pred_taken ? $past(target_addr, 2) :
			$past(branch_addr, 2))))

	// update result: zero prediction, saved fields echoed
	`TBP_ASSERT_IMP(a_update_result, clk, arst_n,
		done && ($past(op, 2) == OP_UPDATE),
		!pred_taken && (next_addr == '0) &&
		(pattern_index == $past(saved_pattern_index, 2)) &&
		(bimodal_vote == $past(saved_bimodal_vote, 2)) &&
		(twolevel_vote == $past(saved_twolevel_vote, 2)))

endmodule

bind tournament_branch_direction_predictor_top tbp_checker u_tbp_checker (.*);

`default_nettype wire
